/* sv/indexed_min_heap_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the indexed min-heap
// Same-cycle and next-cycle implications, clocked on clk_i, off in reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IMH_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IMH_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/imh_pkg.sv */
// ---------------------------------------------------------------------------
// imh_pkg
// Types and codes shared by the indexed min-heap.
// ---------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned KEY_BITS       = 10;
  localparam int unsigned NUM_KEYS       = 1024;
  localparam int unsigned OUT_VALUE_BITS = 32;
  localparam int unsigned DEF_CAPACITY   = 1024;
  localparam int unsigned DEF_VALUE_BITS = 32;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_UPDATE = 3'd1;
  localparam logic [2:0] MODE_DECR   = 3'd2;
  localparam logic [2:0] MODE_POPMIN = 3'd3;
  localparam logic [2:0] MODE_LOOKUP = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;
  localparam logic [2:0] ST_ZERO    = 3'd5;

  typedef struct packed {
    logic [2:0]                mode;
    logic [KEY_BITS-1:0]       item_key;
    logic [OUT_VALUE_BITS-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]       out_key;
    logic [OUT_VALUE_BITS-1:0] out_value;
    logic [2:0]                status;
  } out_t;

endpackage

/* sv/imh_ram.sv */
// ---------------------------------------------------------------------------
// imh_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/indexed_min_heap.sv */
// ---------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with key-to-slot map, one operation per word.
// ---------------------------------------------------------------------------
// Flow: lookup reads the key map, then the heap slot; insert appends at the end and sifts up;
// update/decrement read the slot first, then sift up; popmin takes the root, moves the last
// entry to the root and sifts down; errors and unused modes end early without a sift.
// Every sift step is serialized by the one heap RAM read port.
// One word in flight: in_ready_o only while idle, next word the cycle after result taken.
// Reset: heap empty, then a clearing pass over all 1024 key map entries.
module indexed_min_heap #(
  parameter int unsigned CAPACITY   = imh_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = imh_pkg::DEF_VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  imh_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output imh_pkg::out_t out_data_o
);

  localparam int unsigned KB  = imh_pkg::KEY_BITS;
  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned PW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned IW  = PW + 2;
  localparam int unsigned OVB = imh_pkg::OUT_VALUE_BITS;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_POS   = 14'b00000000000100,
    S_RD    = 14'b00000000001000,
    S_POP0  = 14'b00000000010000,
    S_POPL  = 14'b00000000100000,
    S_UPI   = 14'b00000001000000,
    S_UPC   = 14'b00000010000000,
    S_DNI   = 14'b00000100000000,
    S_DNL   = 14'b00001000000000,
    S_DNR   = 14'b00010000000000,
    S_DNC   = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [KB-1:0]  clr_q, clr_d;
  logic [2:0]     mode_q, mode_d;
  logic [KB-1:0]  key_q, key_d;
  logic [VB-1:0]  val_q, val_d;
  logic [CW-1:0]  count_q, count_d;
  logic [PW-1:0]  at_q, at_d;
  logic [KB-1:0]  cur_key_q, cur_key_d;
  logic [VB-1:0]  cur_val_q, cur_val_d;
  logic [KB-1:0]  ch_key_q, ch_key_d;
  logic [VB-1:0]  ch_val_q, ch_val_d;
  logic [PW-1:0]  ch_idx_q, ch_idx_d;
  logic [KB-1:0]  res_key_q, res_key_d;
  logic [OVB-1:0] res_val_q, res_val_d;
  logic [2:0]     res_st_q, res_st_d;

  // heap RAM: {key, value}
  logic          hp_we;
  logic [PW-1:0] hp_waddr, hp_raddr;
  logic [KB+VB-1:0] hp_wdata, hp_rdata;
  logic [KB-1:0] hp_rkey;
  logic [VB-1:0] hp_rval;

  // key map RAM: {present, slot}
  logic          pm_we;
  logic [KB-1:0] pm_waddr, pm_raddr;
  logic [PW:0]   pm_wdata, pm_rdata;

  logic [IW-1:0] lidx, ridx, cnt_ext;
  logic [PW-1:0] par_idx;
  logic          in_acc;

  assign hp_rkey = hp_rdata[KB+VB-1:VB];
  assign hp_rval = hp_rdata[VB-1:0];
  assign lidx    = IW'({at_q, 1'b1});
  assign ridx    = lidx + IW'(1);
  assign cnt_ext = IW'(count_q);
  assign par_idx = PW'((at_q - PW'(1)) >> 1);
  assign in_acc  = in_valid_i && in_ready_o;

  function automatic logic [OVB-1:0] to_out(input logic [VB-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OVB-1:0];
  endfunction

  imh_ram #(.WIDTH(KB + VB), .DEPTH(CAPACITY)) u_heap (
    .clk_i  (clk_i),
    .we_i   (hp_we),
    .waddr_i(hp_waddr),
    .wdata_i(hp_wdata),
    .raddr_i(hp_raddr),
    .rdata_o(hp_rdata)
  );

  imh_ram #(.WIDTH(PW + 1), .DEPTH(imh_pkg::NUM_KEYS)) u_map (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(pm_wdata),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  always_comb begin
    logic [63:0] in_wide;
    in_wide   = 64'(in_data_i.item_value);
    state_d   = state_q;
    clr_d     = clr_q;
    mode_d    = mode_q;
    key_d     = key_q;
    val_d     = val_q;
    count_d   = count_q;
    at_d      = at_q;
    cur_key_d = cur_key_q;
    cur_val_d = cur_val_q;
    ch_key_d  = ch_key_q;
    ch_val_d  = ch_val_q;
    ch_idx_d  = ch_idx_q;
    res_key_d = res_key_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    hp_we     = 1'b0;
    hp_waddr  = at_q;
    hp_wdata  = {cur_key_q, cur_val_q};
    hp_raddr  = '0;
    pm_we     = 1'b0;
    pm_waddr  = cur_key_q;
    pm_wdata  = {1'b1, at_q};
    pm_raddr  = in_data_i.item_key;

    unique case (state_q)
      S_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        pm_wdata = '0;
        clr_d    = clr_q + KB'(1);
        if (clr_q == KB'(imh_pkg::NUM_KEYS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_d    = in_data_i.mode;
          key_d     = in_data_i.item_key;
          val_d     = in_wide[VB-1:0];
          res_key_d = in_data_i.item_key;
          res_val_d = '0;
          res_st_d  = imh_pkg::ST_OK;
          if (in_data_i.mode == imh_pkg::MODE_POPMIN) begin
            if (count_q == '0) begin
              res_key_d = '0;
              res_st_d  = imh_pkg::ST_EMPTY;
              state_d   = S_OUT;
            end else begin
              state_d = S_POP0;
            end
          end else if (in_data_i.mode == imh_pkg::MODE_INSERT ||
                       in_data_i.mode == imh_pkg::MODE_UPDATE ||
                       in_data_i.mode == imh_pkg::MODE_DECR ||
                       in_data_i.mode == imh_pkg::MODE_LOOKUP) begin
            state_d = S_POS;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_POS: begin
        if (mode_q == imh_pkg::MODE_INSERT) begin
          if (pm_rdata[PW]) begin
            res_st_d = imh_pkg::ST_PRESENT;
            state_d  = S_OUT;
          end else if (count_q == CW'(CAPACITY)) begin
            res_st_d = imh_pkg::ST_FULL;
            state_d  = S_OUT;
          end else begin
            cur_key_d = key_q;
            cur_val_d = val_q;
            at_d      = PW'(count_q);
            count_d   = count_q + CW'(1);
            res_val_d = to_out(val_q);
            state_d   = S_UPI;
          end
        end else if (!pm_rdata[PW]) begin
          res_st_d = imh_pkg::ST_ABSENT;
          state_d  = S_OUT;
        end else begin
          at_d     = pm_rdata[PW-1:0];
          hp_raddr = pm_rdata[PW-1:0];
          state_d  = S_RD;
        end
      end
      S_RD: begin
        cur_key_d = hp_rkey;
        if (mode_q == imh_pkg::MODE_UPDATE) begin
          cur_val_d = val_q;
          res_val_d = to_out(val_q);
          state_d   = S_UPI;
        end else if (mode_q == imh_pkg::MODE_DECR) begin
          if (hp_rval == '0) begin
            res_st_d = imh_pkg::ST_ZERO;
            state_d  = S_OUT;
          end else begin
            cur_val_d = hp_rval - VB'(1);
            res_val_d = to_out(hp_rval - VB'(1));
            state_d   = S_UPI;
          end
        end else begin
          res_val_d = to_out(hp_rval);
          state_d   = S_OUT;
        end
      end
      S_POP0: begin
        res_key_d = hp_rkey;
        res_val_d = to_out(hp_rval);
        pm_we     = 1'b1;
        pm_waddr  = hp_rkey;
        pm_wdata  = '0;
        count_d   = count_q - CW'(1);
        hp_raddr  = PW'(count_q - CW'(1));
        state_d   = (count_q == CW'(1)) ? S_OUT : S_POPL;
      end
      S_POPL: begin
        cur_key_d = hp_rkey;
        cur_val_d = hp_rval;
        at_d      = '0;
        state_d   = S_DNI;
      end
      S_UPI: begin
        hp_raddr = par_idx;
        ch_idx_d = par_idx;
        state_d  = (at_q == '0) ? S_FIN : S_UPC;
      end
      S_UPC: begin
        if (hp_rval <= cur_val_q) begin
          state_d = S_FIN;
        end else begin
          // parent moves down into the hole
          hp_we    = 1'b1;
          hp_wdata = hp_rdata;
          pm_we    = 1'b1;
          pm_waddr = hp_rkey;
          at_d     = ch_idx_q;
          state_d  = S_UPI;
        end
      end
      S_DNI: begin
        hp_raddr = lidx[PW-1:0];
        state_d  = (lidx >= cnt_ext) ? S_FIN : S_DNL;
      end
      S_DNL: begin
        ch_key_d = hp_rkey;
        ch_val_d = hp_rval;
        ch_idx_d = lidx[PW-1:0];
        hp_raddr = ridx[PW-1:0];
        state_d  = (ridx < cnt_ext) ? S_DNR : S_DNC;
      end
      S_DNR: begin
        // right child only when strictly smaller
        if (hp_rval < ch_val_q) begin
          ch_key_d = hp_rkey;
          ch_val_d = hp_rval;
          ch_idx_d = ridx[PW-1:0];
        end
        state_d = S_DNC;
      end
      S_DNC: begin
        if (cur_val_q <= ch_val_q) begin
          state_d = S_FIN;
        end else begin
          hp_we    = 1'b1;
          hp_wdata = {ch_key_q, ch_val_q};
          pm_we    = 1'b1;
          pm_waddr = ch_key_q;
          at_d     = ch_idx_q;
          state_d  = S_DNI;
        end
      end
      S_FIN: begin
        hp_we   = 1'b1;
        pm_we   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    val_q     <= val_d;
    at_q      <= at_d;
    cur_key_q <= cur_key_d;
    cur_val_q <= cur_val_d;
    ch_key_q  <= ch_key_d;
    ch_val_q  <= ch_val_d;
    ch_idx_q  <= ch_idx_d;
    res_key_q <= res_key_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = (state_q == S_OUT);
  assign out_data_o.out_key   = res_key_q;
  assign out_data_o.out_value = res_val_q;
  assign out_data_o.status    = res_st_q;

`include "indexed_min_heap_macros.svh"

  `IMH_CHK_NOW(a_one_word, in_ready_o, !out_valid_o, "input taken while result pending")
  `IMH_CHK_NOW(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "entry count beyond capacity")
  `IMH_CHK_NEXT(a_ret_idle, out_valid_o && out_ready_i, in_ready_o, "not idle after result")

endmodule
